### design/wto_pkg.sv
`timescale 1ns / 1ps

package wto_pkg;

    // Table geometry and fixed-point formats
    localparam int TABLE_LEN   = 1024;
    localparam int IDX_W       = $clog2(TABLE_LEN);
    localparam int BANK_AW     = IDX_W - 1;
    localparam int FRAC_W      = 22;
    localparam int POS_W       = IDX_W + FRAC_W;
    localparam int SAMPLE_BITS = 16;
    localparam int ENTRY_W     = 16;
    localparam int PHASE_W     = 16;
    localparam int STEP_W      = 32;

    // Raised-cosine weight ROM, Q15 weights indexed by the top frac bits
    localparam int ROM_SIZE  = 256;
    localparam int ROM_IDX_W = $clog2(ROM_SIZE);
    localparam int WEIGHT_W  = 16;
    localparam int Q15_SH    = 15;

    // Interpolation datapath
    localparam int COEF_W = FRAC_W + 1;
    localparam int PROD_W = ENTRY_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [COEF_W-1:0] ONE_Q22 = COEF_W'(1) << FRAC_W;
    localparam logic [COEF_W-1:0] ONE_Q15 = COEF_W'(1) << Q15_SH;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_PLAY  = 1'b1
    } func_t;

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_COSINE = 1'b1
    } mode_t;

    typedef enum logic {
        REG_PHASE_STEP  = 1'b0,
        REG_INTERP_MODE = 1'b1
    } reg_idx_t;

    // Control word handed from the read stage to the multiply stage
    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
    } interp_ctrl_t;

    typedef logic [WEIGHT_W-1:0] rom_t [ROM_SIZE];

    // sin(a), a in [0, pi/2), Q30 in and out, Taylor series to a^15
    function automatic logic [63:0] sin_q30(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        a2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        term = ((term * a2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * a2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * a2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        return (sum < 0) ? 64'd0 : $unsigned(sum);
    endfunction

    // w[k] = round(2^15 * sin^2(pi * k / 512))
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] s;
        for (int k = 0; k < ROM_SIZE; k++) begin
            s      = sin_q30((PI_Q30 * 64'(k)) >> 9);
            rom[k] = WEIGHT_W'((s * s + (64'd1 << 44)) >> 45);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

endpackage

### design/wavetable_oscillator_unit.sv
`timescale 1ns / 1ps

// Wavetable oscillator, 1024-entry Q1.15 table, Q10.22 read position.
// A write word (func 0) stores one table entry; a play word (func 1)
// returns one sample interpolated at the current position (linear, or
// raised cosine through a 256-entry weight ROM) and then advances the
// position by phase_step, optionally scaled by (phase_mod + 1) / 2. One word
// is taken every cycle while s_ready is high; a play result reaches m_ through
// the table read, the multiply, then the sum/round into the result queue. The
// table sits in two 512x16 banks (even and odd entries) so both neighbors are
// read in the same cycle; it needs no clearing, but every entry must be written
// before it is played.
// Results queue in an OUT_DEPTH-word buffer: s_ready drops only when that
// buffer plus the plays in flight already fill it, so with m_ready held high
// and OUT_DEPTH of 4 or more the block sustains one word per cycle.
module wavetable_oscillator_unit #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [wto_pkg::IDX_W-1:0]           s_entry_index,
    input  logic signed [wto_pkg::ENTRY_W-1:0]  s_entry_value,
    input  logic                                s_use_phase,
    input  logic signed [wto_pkg::PHASE_W-1:0]  s_phase_mod,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wto_pkg::SAMPLE_BITS-1:0] m_sample_out
);

    localparam int CNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int CREDIT_W = CNT_W + 1;
    localparam int MUL_W    = wto_pkg::STEP_W + wto_pkg::PHASE_W;

    // configuration registers
    logic [wto_pkg::STEP_W-1:0] phase_step_reg;
    wto_pkg::mode_t             interp_mode_reg;
    wto_pkg::reg_idx_t          reg_sel;
    logic                       cfg_wr;

    // position: the step of the previous play is folded in at the next play
    logic [wto_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [wto_pkg::STEP_W-1:0] pend_reg, pend_next;
    logic [wto_pkg::POS_W-1:0]  cur_pos;
    logic [wto_pkg::FRAC_W-1:0] frac;
    logic [wto_pkg::WEIGHT_W-1:0] weight;
    logic [wto_pkg::PHASE_W-1:0]  scale;
    logic [MUL_W-1:0]             scaled_step;
    logic [wto_pkg::STEP_W-1:0]   step;

    logic accept;
    logic play;
    logic store;

    wto_pkg::interp_ctrl_t ctrl_reg, ctrl_next;

    logic signed [wto_pkg::ENTRY_W-1:0] prev_sample;
    logic signed [wto_pkg::ENTRY_W-1:0] next_sample;
    logic                               res_valid;
    logic [wto_pkg::SAMPLE_BITS-1:0]    res_sample;
    logic [wto_pkg::SAMPLE_BITS-1:0]    out_data;
    logic [CNT_W-1:0]                   out_count;
    logic [CREDIT_W-1:0]                in_flight;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign reg_sel = wto_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg  <= '0;
            interp_mode_reg <= wto_pkg::MODE_LINEAR;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                wto_pkg::REG_PHASE_STEP:  phase_step_reg  <= pwdata;
                wto_pkg::REG_INTERP_MODE: interp_mode_reg <= wto_pkg::mode_t'(pwdata[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            wto_pkg::REG_PHASE_STEP:  prdata = phase_step_reg;
            wto_pkg::REG_INTERP_MODE: prdata = {31'b0, interp_mode_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---- input handshake, credit against the result queue ----
    assign in_flight = CREDIT_W'(out_count) + CREDIT_W'(ctrl_reg.valid)
                       + CREDIT_W'(res_valid);
    assign s_ready   = (in_flight < CREDIT_W'(OUT_DEPTH));
    assign accept    = s_valid && s_ready;
    assign play      = accept && (wto_pkg::func_t'(s_func) == wto_pkg::FUNC_PLAY);
    assign store     = accept && (wto_pkg::func_t'(s_func) == wto_pkg::FUNC_WRITE);

    // ---- position and step ----
    assign cur_pos     = pos_reg + pend_reg;
    assign frac        = cur_pos[wto_pkg::FRAC_W-1:0];
    assign weight      = wto_pkg::COS_ROM[frac[wto_pkg::FRAC_W-1 -: wto_pkg::ROM_IDX_W]];
    assign scale       = {~s_phase_mod[wto_pkg::PHASE_W-1], s_phase_mod[wto_pkg::PHASE_W-2:0]};
    assign scaled_step = phase_step_reg * scale;
    assign step        = s_use_phase ? scaled_step[MUL_W-1 -: wto_pkg::STEP_W]
                                     : phase_step_reg;

    always_comb begin
        pos_next  = pos_reg;
        pend_next = pend_reg;
        if (play) begin
            pos_next  = cur_pos;
            pend_next = step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            pend_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // ---- interpolation weights, registered alongside the table read ----
    always_comb begin
        ctrl_next.valid = play;
        ctrl_next.mode  = interp_mode_reg;
        if (interp_mode_reg == wto_pkg::MODE_COSINE) begin
            ctrl_next.coef_a = wto_pkg::ONE_Q15 - wto_pkg::COEF_W'(weight);
            ctrl_next.coef_b = wto_pkg::COEF_W'(weight);
        end else begin
            ctrl_next.coef_a = wto_pkg::ONE_Q22 - wto_pkg::COEF_W'(frac);
            ctrl_next.coef_b = wto_pkg::COEF_W'(frac);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    wto_wave_mem u_wave_mem (
        .aclk        (aclk),
        .wr_en       (store),
        .wr_idx      (s_entry_index),
        .wr_data     (s_entry_value),
        .rd_en       (play),
        .rd_base     (cur_pos[wto_pkg::POS_W-1 -: wto_pkg::IDX_W]),
        .prev_sample (prev_sample),
        .next_sample (next_sample)
    );

    wto_interp u_interp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl_reg),
        .prev_sample (prev_sample),
        .next_sample (next_sample),
        .res_valid   (res_valid),
        .res_sample  (res_sample)
    );

    wto_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (res_valid),
        .wr_data (res_sample),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (out_data),
        .count   (out_count)
    );

    assign m_sample_out = $signed(out_data);

endmodule

### design/wto_wave_mem.sv
`timescale 1ns / 1ps

// Wave table split into even and odd banks so both neighbors of a position
// come out in the same cycle, one read port per bank.
module wto_wave_mem (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [wto_pkg::IDX_W-1:0]        wr_idx,
    input  logic signed [wto_pkg::ENTRY_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [wto_pkg::IDX_W-1:0]        rd_base,
    output logic signed [wto_pkg::ENTRY_W-1:0] prev_sample,
    output logic signed [wto_pkg::ENTRY_W-1:0] next_sample
);

    logic [wto_pkg::ENTRY_W-1:0] even_mem [2**wto_pkg::BANK_AW];
    logic [wto_pkg::ENTRY_W-1:0] odd_mem  [2**wto_pkg::BANK_AW];

    logic [wto_pkg::ENTRY_W-1:0] even_q_reg;
    logic [wto_pkg::ENTRY_W-1:0] odd_q_reg;
    logic                        odd_base_reg;

    logic [wto_pkg::BANK_AW-1:0] half_idx;
    logic [wto_pkg::BANK_AW-1:0] even_addr;

    // Odd base: upper neighbor is the next even entry, wrapping to entry 0
    assign half_idx  = rd_base[wto_pkg::IDX_W-1:1];
    assign even_addr = rd_base[0] ? half_idx + wto_pkg::BANK_AW'(1) : half_idx;

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_idx[0]) begin
            even_mem[wr_idx[wto_pkg::IDX_W-1:1]] <= wr_data;
        end
        if (rd_en) begin
            even_q_reg <= even_mem[even_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_idx[0]) begin
            odd_mem[wr_idx[wto_pkg::IDX_W-1:1]] <= wr_data;
        end
        if (rd_en) begin
            odd_q_reg <= odd_mem[half_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            odd_base_reg <= rd_base[0];
        end
    end

    assign prev_sample = odd_base_reg ? $signed(odd_q_reg)  : $signed(even_q_reg);
    assign next_sample = odd_base_reg ? $signed(even_q_reg) : $signed(odd_q_reg);

endmodule

### design/wto_interp.sv
`timescale 1ns / 1ps

// Two-tap weighted sum: products registered, then sum, round, saturate.
module wto_interp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  wto_pkg::interp_ctrl_t              ctrl,
    input  logic signed [wto_pkg::ENTRY_W-1:0] prev_sample,
    input  logic signed [wto_pkg::ENTRY_W-1:0] next_sample,
    output logic                               res_valid,
    output logic [wto_pkg::SAMPLE_BITS-1:0]    res_sample
);

    localparam logic signed [wto_pkg::SUM_W-1:0] SAT_HI =
        wto_pkg::SUM_W'((64'd1 << (wto_pkg::SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [wto_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - wto_pkg::SUM_W'(1);
    localparam logic [wto_pkg::SUM_W-1:0] BIAS_Q22 =
        wto_pkg::SUM_W'(1) << (wto_pkg::FRAC_W - 1);
    localparam logic [wto_pkg::SUM_W-1:0] BIAS_Q15 =
        wto_pkg::SUM_W'(1) << (wto_pkg::Q15_SH - 1);

    logic signed [wto_pkg::PROD_W-1:0] prod_a_next;
    logic signed [wto_pkg::PROD_W-1:0] prod_b_next;
    logic signed [wto_pkg::PROD_W-1:0] prod_a_reg;
    logic signed [wto_pkg::PROD_W-1:0] prod_b_reg;
    wto_pkg::mode_t                    mode_reg;
    logic                              valid_reg;

    logic signed [wto_pkg::SUM_W-1:0] acc;
    logic signed [wto_pkg::SUM_W-1:0] shifted;

    assign prod_a_next = prev_sample * $signed({1'b0, ctrl.coef_a});
    assign prod_b_next = next_sample * $signed({1'b0, ctrl.coef_b});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        mode_reg   <= ctrl.mode;
    end

    always_comb begin
        if (mode_reg == wto_pkg::MODE_COSINE) begin
            acc     = wto_pkg::SUM_W'(prod_a_reg) + wto_pkg::SUM_W'(prod_b_reg)
                      + $signed(BIAS_Q15);
            shifted = acc >>> wto_pkg::Q15_SH;
        end else begin
            acc     = wto_pkg::SUM_W'(prod_a_reg) + wto_pkg::SUM_W'(prod_b_reg)
                      + $signed(BIAS_Q22);
            shifted = acc >>> wto_pkg::FRAC_W;
        end
        if (shifted > SAT_HI) begin
            res_sample = SAT_HI[wto_pkg::SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            res_sample = SAT_LO[wto_pkg::SAMPLE_BITS-1:0];
        end else begin
            res_sample = shifted[wto_pkg::SAMPLE_BITS-1:0];
        end
    end

    assign res_valid = valid_reg;

endmodule

### design/wto_out_fifo.sv
`timescale 1ns / 1ps

// Result queue; the top level only issues a play when a slot is reserved.
module wto_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [wto_pkg::SAMPLE_BITS-1:0] wr_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wto_pkg::SAMPLE_BITS-1:0] m_data,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [wto_pkg::SAMPLE_BITS-1:0] fifo_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             rd_en;

    assign rd_en = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fifo_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_mem[rd_ptr_reg];
    assign count   = count_reg;

endmodule

### tb/sv/wavetable_oscillator_unit_tb.sv
`timescale 1ns / 1ps

module wavetable_oscillator_unit_tb;

    localparam logic [63:0] PI_FIXED = 64'd3373259426;   // pi in Q30
    localparam int DRAIN_CYCLES = 8;                       // pipeline is 3 deep

    typedef struct {
        wto_pkg::func_t                     func;
        logic [wto_pkg::IDX_W-1:0]          entry_index;
        logic signed [wto_pkg::ENTRY_W-1:0] entry_value;
        logic                               use_phase;
        logic signed [wto_pkg::PHASE_W-1:0] phase_mod;
    } osc_word_t;

    class osc_scoreboard;
        logic signed [wto_pkg::ENTRY_W-1:0] wave [wto_pkg::TABLE_LEN];
        bit                                 written [wto_pkg::TABLE_LEN];
        logic [31:0]                        pos;
        logic [31:0]                        step_reg;
        wto_pkg::mode_t                     mode;
        logic [15:0]                        weight [wto_pkg::ROM_SIZE];
        logic signed [15:0]                 pending_samples [$];
        int                                 errors;

        function new();
            logic [63:0] a;
            logic [63:0] a2;
            logic [63:0] term;
            logic [63:0] s;
            longint      sum;
            pos      = '0;
            step_reg = '0;
            mode     = wto_pkg::MODE_LINEAR;
            errors   = 0;
            // raised-cosine weights: sin^2 via a Q30 Taylor series
            for (int k = 0; k < wto_pkg::ROM_SIZE; k++) begin
                a    = (PI_FIXED * k) / 512;
                a2   = (a * a) >> 30;
                term = a;
                sum  = a;
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * a2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                    if (n % 2) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                s = (sum < 0) ? 64'd0 : 64'(sum);
                weight[k] = 16'((s * s + (64'd1 << 44)) >> 45);
            end
        endfunction

        function void set_reg(wto_pkg::reg_idx_t r, logic [31:0] v);
            if (r == wto_pkg::REG_PHASE_STEP) begin
                step_reg = v;
            end else begin
                mode = wto_pkg::mode_t'(v[0]);
            end
        endfunction

        function void note_word(osc_word_t w);
            logic [wto_pkg::IDX_W-1:0]  b;
            logic [wto_pkg::IDX_W-1:0]  nb;
            logic [wto_pkg::FRAC_W-1:0] f;
            longint                     prev;
            longint                     nxt;
            longint                     wgt;
            longint                     acc;
            longint                     y;
            logic [63:0]                stp;
            int                         scale;
            if (w.func == wto_pkg::FUNC_WRITE) begin
                wave[w.entry_index]    = w.entry_value;
                written[w.entry_index] = 1'b1;
                return;
            end
            b    = pos[31:wto_pkg::FRAC_W];
            nb   = b + 1'b1;
            f    = pos[wto_pkg::FRAC_W-1:0];
            prev = wave[b];
            nxt  = wave[nb];
            if (mode == wto_pkg::MODE_COSINE) begin
                wgt = weight[f[wto_pkg::FRAC_W-1 -: 8]];
                acc = prev * (32768 - wgt) + nxt * wgt;
                y   = (acc + 16384) >>> 15;
            end else begin
                acc = prev * ((longint'(1) << wto_pkg::FRAC_W) - longint'(f))
                      + nxt * longint'(f);
                y   = (acc + (longint'(1) << (wto_pkg::FRAC_W - 1))) >>> wto_pkg::FRAC_W;
            end
            if (y > 32767) begin
                y = 32767;
            end else if (y < -32768) begin
                y = -32768;
            end
            pending_samples.push_back(16'(y));
            stp = 64'(step_reg);
            if (w.use_phase) begin
                scale = int'(w.phase_mod) + 32768;
                stp   = (stp * 64'(scale)) >> 16;
            end
            pos = pos + stp[31:0];   // position wraps mod 2^32 = TABLE_LEN << FRAC_W
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] exp_s;
            if (pending_samples.size() == 0) begin
                $error("sample_out: unexpected word, actual %0d", got);
                errors++;
                return;
            end
            exp_s = pending_samples.pop_front();
            if (got !== exp_s) begin
                $error("sample_out: expected %0d, actual %0d", exp_s, got);
                errors++;
            end
        endfunction
    endclass

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   psel = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite = 1'b0;
    logic [2:0]                             paddr = '0;
    logic [31:0]                            pwdata = '0;
    logic [31:0]                            prdata;
    logic                                   pready;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic                                   s_func = 1'b0;
    logic [wto_pkg::IDX_W-1:0]              s_entry_index = '0;
    logic signed [wto_pkg::ENTRY_W-1:0]     s_entry_value = '0;
    logic                                   s_use_phase = 1'b0;
    logic signed [wto_pkg::PHASE_W-1:0]     s_phase_mod = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic signed [wto_pkg::SAMPLE_BITS-1:0] m_sample_out;

    osc_scoreboard sb = new();

    int src_idle = 0;
    int snk_stall = 0;
    int hold_left = 0;
    int idle_pct[4]  = '{0, 56, 0, 28};
    int stall_pct[4] = '{0, 0, 56, 28};

    wavetable_oscillator_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_use_phase   (s_use_phase),
        .s_phase_mod   (s_phase_mod),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus a long hold when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= snk_stall);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_sample(m_sample_out);
        end
    end

    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic osc_word_t rand_word(wto_pkg::func_t f);
        osc_word_t w;
        w.func        = f;
        w.entry_index = wto_pkg::IDX_W'($urandom);
        w.entry_value = rand_q15();
        w.use_phase   = 1'($urandom);
        w.phase_mod   = rand_q15();
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after the handshake
    task automatic send_word(osc_word_t w);
        while ($urandom_range(99) < src_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_func        = w.func;
        s_entry_index = w.entry_index;
        s_entry_value = w.entry_value;
        s_use_phase   = w.use_phase;
        s_phase_mod   = w.phase_mod;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    task automatic write_entry(logic [wto_pkg::IDX_W-1:0] idx, logic signed [15:0] v);
        osc_word_t w;
        w = rand_word(wto_pkg::FUNC_WRITE);
        w.entry_index = idx;
        w.entry_value = v;
        send_word(w);
    endtask

    // loads any neighbor not yet written, then plays
    task automatic play_at(logic up, logic signed [15:0] pm);
        osc_word_t w;
        logic [wto_pkg::IDX_W-1:0] b;
        b = sb.pos[31:wto_pkg::FRAC_W];
        while (!sb.written[b] || !sb.written[wto_pkg::IDX_W'(b + 1)]) begin
            write_entry(sb.written[b] ? wto_pkg::IDX_W'(b + 1) : b, rand_q15());
        end
        w = rand_word(wto_pkg::FUNC_PLAY);
        w.use_phase = up;
        w.phase_mod = pm;
        send_word(w);
    endtask

    task automatic send_random();
        osc_word_t w;
        logic [wto_pkg::IDX_W-1:0] b;
        int r;
        b = sb.pos[31:wto_pkg::FRAC_W];
        r = $urandom_range(99);
        w = rand_word(wto_pkg::FUNC_WRITE);
        if (!sb.written[b]) begin
            w.entry_index = b;
        end else if (!sb.written[wto_pkg::IDX_W'(b + 1)]) begin
            w.entry_index = wto_pkg::IDX_W'(b + 1);
        end else if (r < 50) begin
            w.func = wto_pkg::FUNC_PLAY;
        end else if (r < 60) begin
            // overwrite a neighbor right under the read position
            w.entry_index = wto_pkg::IDX_W'(b + $urandom_range(1));
        end
        send_word(w);
    endtask

    task automatic apb_write(wto_pkg::reg_idx_t r, logic [31:0] v);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(r, v);
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        readback = (r == wto_pkg::REG_PHASE_STEP) ? v : {31'b0, v[0]};
        if (prdata !== readback) begin
            $error("prdata: expected %0h, actual %0h", readback, prdata);
            sb.errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // sender pauses until every expected sample is back, then lets the pipe empty
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0]    st;
        wto_pkg::mode_t md;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, half steps, scale 0 and full, backward wrap
        apb_write(wto_pkg::REG_PHASE_STEP, 32'd0);
        apb_write(wto_pkg::REG_INTERP_MODE, 32'(wto_pkg::MODE_LINEAR));
        write_entry(10'd0, 16'sh7FFF);
        write_entry(10'd1, 16'sh8000);
        write_entry(10'd2, 16'sh0000);
        write_entry(10'd1023, 16'sh8000);
        play_at(1'b0, 16'sd0);
        drain();
        apb_write(wto_pkg::REG_PHASE_STEP, 32'h0020_0000);
        play_at(1'b0, 16'sd0);
        play_at(1'b0, 16'sd0);
        play_at(1'b0, 16'sd0);
        play_at(1'b1, 16'sh8000);
        play_at(1'b1, 16'sh7FFF);
        drain();
        apb_write(wto_pkg::REG_PHASE_STEP, 32'hFFC0_0000);   // one entry back per sample
        play_at(1'b0, 16'sd0);
        play_at(1'b0, 16'sd0);
        play_at(1'b0, 16'sd0);
        drain();
        apb_write(wto_pkg::REG_INTERP_MODE, 32'(wto_pkg::MODE_COSINE));
        apb_write(wto_pkg::REG_PHASE_STEP, 32'h0010_0000);
        play_at(1'b0, 16'sd0);
        play_at(1'b0, 16'sd0);
        play_at(1'b1, 16'sh7FFF);
        drain();
        apb_write(wto_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        play_at(1'b1, -16'sd1);
        play_at(1'b0, 16'sd0);

        for (int ph = 0; ph < 12; ph++) begin
            drain();
            md = wto_pkg::mode_t'(ph % 2);
            case (ph)
                0: st = 32'h0040_0000;
                1: st = $urandom;
                2: st = 32'h4000_0000;          // lands exactly on the wrap point
                3: st = 32'hFFFF_FFFF;
                4: st = $urandom_range(1, 32'h0080_0000);
                5: st = 32'd0;
                default: begin
                    st = $urandom_range(1) ? $urandom : $urandom_range(1, 32'h0100_0000);
                    md = wto_pkg::mode_t'($urandom_range(1));
                end
            endcase
            apb_write(wto_pkg::REG_PHASE_STEP, st);
            apb_write(wto_pkg::REG_INTERP_MODE, 32'(md));
            src_idle  = idle_pct[ph % 4];
            snk_stall = stall_pct[ph % 4];
            if (ph == 4) begin
                hold_left = 300;   // output side blocked, input must back up
            end
            repeat (120) send_random();
        end
        drain();

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
design/wto_pkg.sv
design/wto_wave_mem.sv
design/wto_interp.sv
design/wto_out_fifo.sv
design/wavetable_oscillator_unit.sv
tb/sv/wavetable_oscillator_unit_tb.sv
